>>> hw/rtl/compose_flow_bilinear_unit_macros.svh
// Assertion macros shared by the flow composition unit.
`ifndef COMPOSE_FLOW_BILINEAR_UNIT_MACROS_SVH
`define COMPOSE_FLOW_BILINEAR_UNIT_MACROS_SVH

// Checked on every edge, reset or not.
`define CFB_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

// Checked only outside reset.
`define CFB_ASSERT_RUN(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> hw/rtl/cfb_pkg.sv
// Shared types and constants of the flow composition unit.
package cfb_pkg;

    localparam int FIELD_W = 18;
    localparam int POS_W   = 9;
    localparam int CFG_W   = 10;
    localparam int STORE_W = 2 * FIELD_W;

    localparam logic signed [FIELD_W-1:0] SAT_HI = 18'sh1FFFF;
    localparam logic signed [FIELD_W-1:0] SAT_LO = 18'sh20000;

    typedef enum logic
    {
        OP_LOAD    = 1'b0,
        OP_COMPOSE = 1'b1
    } opcode_t;

    typedef enum logic
    {
        REG_ROWS = 1'b0,
        REG_COLS = 1'b1
    } reg_index_t;

    // Item data carried alongside the arithmetic pipeline.
    typedef struct packed
    {
        logic [POS_W-1:0]          row;
        logic [POS_W-1:0]          col;
        logic signed [FIELD_W-1:0] fx;
        logic signed [FIELD_W-1:0] fy;
    } item_tag_t;

endpackage

>>> hw/rtl/cfb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cfb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 65536
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic                                 re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/compose_flow_bilinear_unit.sv
// Top level of the flow composition unit: banked store and bilinear pipeline.
//
// Input channel (item_valid/item_stall): opcode 0 loads one entry of the
// second flow field at (pixel_row, pixel_col); opcode 1 composes at that pixel.
// A load whose pixel lies inside the store is written at the edge of its
// transfer and gives no result. A compose gives one result on the output
// channel (result_valid/result_stall) after store read, horizontal weighting,
// vertical weighting, and rounding, flow addition and saturation.
// Throughput is one item per cycle while item_stall is low. The store is
// split into four banks by row and column parity, so the four neighbours of
// a pixel come from four separate read ports in the same cycle.
// A stalled result holds in the output register; earlier stages keep
// advancing while bubbles remain, and item_stall rises only when every stage
// holds an item.
// Reset clears the pipeline and sets both size registers to 512 (limited to
// the store size). The store itself is not cleared: an entry must be loaded
// before a compose reads it. Write a size register with wr_en only while the
// unit is idle (not enforced); 0 acts as 1, a value beyond the store as its max.
`include "compose_flow_bilinear_unit_macros.svh"

module compose_flow_bilinear_unit #(
    parameter int MAX_ROWS  = 512,
    parameter int MAX_COLS  = 512,
    parameter int FRAC_BITS = 6
) (
    input  logic                                 clk,
    input  logic                                 rst_n,

    input  logic                                 wr_en,
    input  logic                                 wr_index,
    input  logic [cfb_pkg::CFG_W-1:0]            wr_data,

    input  logic                                 item_valid,
    output logic                                 item_stall,
    input  logic                                 opcode,
    input  logic [cfb_pkg::POS_W-1:0]            pixel_row,
    input  logic [cfb_pkg::POS_W-1:0]            pixel_col,
    input  logic signed [cfb_pkg::FIELD_W-1:0]   flow_x,
    input  logic signed [cfb_pkg::FIELD_W-1:0]   flow_y,

    output logic                                 result_valid,
    input  logic                                 result_stall,
    output logic [cfb_pkg::POS_W-1:0]            out_row,
    output logic [cfb_pkg::POS_W-1:0]            out_col,
    output logic signed [cfb_pkg::FIELD_W-1:0]   composed_x,
    output logic signed [cfb_pkg::FIELD_W-1:0]   composed_y
);

    localparam int FW  = cfb_pkg::FIELD_W;
    localparam int PW  = cfb_pkg::POS_W;
    localparam int F   = FRAC_BITS;
    localparam int DW  = (((PW + F) > FW) ? (PW + F) : FW) + 2;
    localparam int IW  = (((DW - F) > 13) ? (DW - F) : 13) + 2;
    localparam int RW  = $clog2(MAX_ROWS);
    localparam int CW  = $clog2(MAX_COLS);
    localparam int NRW = $clog2(MAX_ROWS + 1);
    localparam int NCW = $clog2(MAX_COLS + 1);
    localparam int LW  = 14;
    localparam int HW  = FW + F + 2;
    localparam int VW  = HW + F + 2;
    localparam int SW  = FW + 2;

    localparam int BANK_ROWS  = (MAX_ROWS + 1) / 2;
    localparam int BANK_COLS  = (MAX_COLS + 1) / 2;
    localparam int BANK_DEPTH = BANK_ROWS * BANK_COLS;
    localparam int BAW        = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

    localparam logic [NRW-1:0] ROWS_RST = NRW'((MAX_ROWS < 512) ? MAX_ROWS : 512);
    localparam logic [NCW-1:0] COLS_RST = NCW'((MAX_COLS < 512) ? MAX_COLS : 512);
    localparam logic [F:0]     FULL_WT  = (F + 1)'(1) << F;
    localparam logic signed [VW-1:0] RND = VW'(1) << (2 * F - 1);

    function automatic logic [BAW-1:0] bank_addr(input logic [12:0] r,
                                                 input logic [12:0] c);
        logic [25:0] a;
        a = 26'(r >> 1) * 26'(BANK_COLS) + 26'(c >> 1);
        return a[BAW-1:0];
    endfunction

    // ---------------------------------------------------------------- config
    logic [NRW-1:0] rows_lim_reg, rows_lim_next;
    logic [NCW-1:0] cols_lim_reg, cols_lim_next;

    always_comb
    begin
        rows_lim_next = rows_lim_reg;
        cols_lim_next = cols_lim_reg;
        if (wr_en)
        begin
            case (wr_index)
                cfb_pkg::REG_ROWS:
                begin
                    if (wr_data == '0)
                        rows_lim_next = NRW'(1);
                    else if (LW'(wr_data) > LW'(MAX_ROWS))
                        rows_lim_next = NRW'(MAX_ROWS);
                    else
                        rows_lim_next = NRW'(wr_data);
                end
                cfb_pkg::REG_COLS:
                begin
                    if (wr_data == '0)
                        cols_lim_next = NCW'(1);
                    else if (LW'(wr_data) > LW'(MAX_COLS))
                        cols_lim_next = NCW'(MAX_COLS);
                    else
                        cols_lim_next = NCW'(wr_data);
                end
                default:
                begin
                    rows_lim_next = rows_lim_reg;
                end
            endcase
        end
    end

    // --------------------------------------------------------- flow control
    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;
    logic item_xfer, load_we, comp_re;

    assign en4 = !v4_reg || !result_stall;
    assign en3 = !v3_reg || en4;
    assign en2 = !v2_reg || en3;
    assign en1 = !v1_reg || en2;

    assign item_stall = !en1;
    assign item_xfer  = item_valid && !item_stall;
    assign comp_re    = item_xfer && (opcode == cfb_pkg::OP_COMPOSE);
    assign load_we    = item_xfer && (opcode == cfb_pkg::OP_LOAD)
                        && (LW'(pixel_row) < LW'(MAX_ROWS))
                        && (LW'(pixel_col) < LW'(MAX_COLS));

    // ------------------------------------------------- displaced positions
    logic signed [DW-1:0] dr, dc;
    logic signed [IW-1:0] fr, fc, fr1, fc1, nr_i, nc_i;
    logic signed [IW-1:0] r0_i, r1_i, c0_i, c1_i;
    logic [RW-1:0] r0, r1;
    logic [CW-1:0] c0, c1;

    always_comb
    begin
        dr   = $signed(DW'({pixel_row, {F{1'b0}}})) + DW'(flow_y);
        dc   = $signed(DW'({pixel_col, {F{1'b0}}})) + DW'(flow_x);
        fr   = IW'($signed(dr[DW-1:F]));
        fc   = IW'($signed(dc[DW-1:F]));
        fr1  = fr + IW'(1);
        fc1  = fc + IW'(1);
        nr_i = $signed(IW'(rows_lim_reg));
        nc_i = $signed(IW'(cols_lim_reg));

        r0_i = (fr < 0) ? '0 : ((fr >= nr_i) ? nr_i - IW'(1) : fr);
        r1_i = (fr1 < 0) ? '0 : ((fr1 >= nr_i) ? nr_i - IW'(1) : fr1);
        c0_i = (fc < 0) ? '0 : ((fc >= nc_i) ? nc_i - IW'(1) : fc);
        c1_i = (fc1 < 0) ? '0 : ((fc1 >= nc_i) ? nc_i - IW'(1) : fc1);

        r0 = r0_i[RW-1:0];
        r1 = r1_i[RW-1:0];
        c0 = c0_i[CW-1:0];
        c1 = c1_i[CW-1:0];
    end

    // ------------------------------------------------------------ store
    logic [1:0]                    wbank;
    logic [BAW-1:0]                waddr;
    logic [cfb_pkg::STORE_W-1:0]   wdata;
    logic [cfb_pkg::STORE_W-1:0]   bank_q [4];

    assign wbank = {pixel_row[0], pixel_col[0]};
    assign waddr = bank_addr(13'(pixel_row), 13'(pixel_col));
    assign wdata = {flow_x, flow_y};

    for (genvar b = 0; b < 4; b++)
    begin : g_bank
        logic [RW-1:0]  rsel;
        logic [CW-1:0]  csel;
        logic [BAW-1:0] raddr;

        assign rsel  = (r0[0] == 1'(b >> 1)) ? r0 : r1;
        assign csel  = (c0[0] == 1'(b & 1)) ? c0 : c1;
        assign raddr = bank_addr(13'(rsel), 13'(csel));

        cfb_ram #(
            .WIDTH (cfb_pkg::STORE_W),
            .DEPTH (BANK_DEPTH)
        ) u_ram (
            .clk   (clk),
            .we    (load_we && (wbank == 2'(b))),
            .waddr (waddr),
            .wdata (wdata),
            .re    (comp_re),
            .raddr (raddr),
            .rdata (bank_q[b])
        );
    end

    // ------------------------------------------------------ stage 1 (read)
    cfb_pkg::item_tag_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [F-1:0] s1_tr_reg, s1_tc_reg, s2_tr_reg;
    logic [1:0]   s1_i00_reg, s1_i01_reg, s1_i10_reg, s1_i11_reg;

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_tag_reg <= '{row: pixel_row, col: pixel_col, fx: flow_x, fy: flow_y};
            s1_tr_reg  <= dr[F-1:0];
            s1_tc_reg  <= dc[F-1:0];
            s1_i00_reg <= {r0[0], c0[0]};
            s1_i01_reg <= {r0[0], c1[0]};
            s1_i10_reg <= {r1[0], c0[0]};
            s1_i11_reg <= {r1[0], c1[0]};
        end
    end

    // ------------------------------------------- stage 2 (horizontal blend)
    logic [cfb_pkg::STORE_W-1:0] p00, p01, p10, p11;
    logic [F:0]                  wc0, wc1;
    logic signed [HW-1:0]        wc0_s, wc1_s;
    logic signed [HW-1:0]        hx0_next, hx1_next, hy0_next, hy1_next;
    logic signed [HW-1:0]        hx0_reg, hx1_reg, hy0_reg, hy1_reg;

    always_comb
    begin
        p00   = bank_q[s1_i00_reg];
        p01   = bank_q[s1_i01_reg];
        p10   = bank_q[s1_i10_reg];
        p11   = bank_q[s1_i11_reg];
        wc1   = {1'b0, s1_tc_reg};
        wc0   = FULL_WT - wc1;
        wc0_s = $signed(HW'(wc0));
        wc1_s = $signed(HW'(wc1));

        hx0_next = HW'($signed(p00[2*FW-1:FW])) * wc0_s
                 + HW'($signed(p01[2*FW-1:FW])) * wc1_s;
        hx1_next = HW'($signed(p10[2*FW-1:FW])) * wc0_s
                 + HW'($signed(p11[2*FW-1:FW])) * wc1_s;
        hy0_next = HW'($signed(p00[FW-1:0])) * wc0_s
                 + HW'($signed(p01[FW-1:0])) * wc1_s;
        hy1_next = HW'($signed(p10[FW-1:0])) * wc0_s
                 + HW'($signed(p11[FW-1:0])) * wc1_s;
    end

    always_ff @(posedge clk)
    begin
        if (en2)
        begin
            s2_tag_reg <= s1_tag_reg;
            s2_tr_reg  <= s1_tr_reg;
            hx0_reg    <= hx0_next;
            hx1_reg    <= hx1_next;
            hy0_reg    <= hy0_next;
            hy1_reg    <= hy1_next;
        end
    end

    // --------------------------------------------- stage 3 (vertical blend)
    logic [F:0]           wr0, wr1;
    logic signed [VW-1:0] wr0_s, wr1_s;
    logic signed [VW-1:0] vx_next, vy_next, vx_reg, vy_reg;

    always_comb
    begin
        wr1     = {1'b0, s2_tr_reg};
        wr0     = FULL_WT - wr1;
        wr0_s   = $signed(VW'(wr0));
        wr1_s   = $signed(VW'(wr1));
        vx_next = VW'(hx0_reg) * wr0_s + VW'(hx1_reg) * wr1_s;
        vy_next = VW'(hy0_reg) * wr0_s + VW'(hy1_reg) * wr1_s;
    end

    always_ff @(posedge clk)
    begin
        if (en3)
        begin
            s3_tag_reg <= s2_tag_reg;
            vx_reg     <= vx_next;
            vy_reg     <= vy_next;
        end
    end

    // -------------------------------------- stage 4 (round, add, saturate)
    logic signed [VW-1:0] rx, ry;
    logic signed [SW-1:0] sx, sy;
    logic signed [FW-1:0] cx_next, cy_next, cx_reg, cy_reg;

    always_comb
    begin
        rx = (vx_reg + RND) >>> (2 * F);
        ry = (vy_reg + RND) >>> (2 * F);
        sx = $signed(rx[SW-1:0]) + SW'(s3_tag_reg.fx);
        sy = $signed(ry[SW-1:0]) + SW'(s3_tag_reg.fy);

        if (sx > SW'(cfb_pkg::SAT_HI))
            cx_next = cfb_pkg::SAT_HI;
        else if (sx < SW'(cfb_pkg::SAT_LO))
            cx_next = cfb_pkg::SAT_LO;
        else
            cx_next = sx[FW-1:0];

        if (sy > SW'(cfb_pkg::SAT_HI))
            cy_next = cfb_pkg::SAT_HI;
        else if (sy < SW'(cfb_pkg::SAT_LO))
            cy_next = cfb_pkg::SAT_LO;
        else
            cy_next = sy[FW-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en4)
        begin
            s4_tag_reg <= s3_tag_reg;
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
        end
    end

    // ------------------------------------------------------ control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_lim_reg <= ROWS_RST;
            cols_lim_reg <= COLS_RST;
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
        end
        else
        begin
            rows_lim_reg <= rows_lim_next;
            cols_lim_reg <= cols_lim_next;
            if (en1)
                v1_reg <= comp_re;
            if (en2)
                v2_reg <= v1_reg;
            if (en3)
                v3_reg <= v2_reg;
            if (en4)
                v4_reg <= v3_reg;
        end
    end

    assign result_valid = v4_reg;
    assign out_row      = s4_tag_reg.row;
    assign out_col      = s4_tag_reg.col;
    assign composed_x   = cx_reg;
    assign composed_y   = cy_reg;

    // ----------------------------------------------------------- checks
    logic            pipe_full, result_held;
    logic [2*FW-1:0] result_word;

    assign pipe_full   = v1_reg && v2_reg && v3_reg && v4_reg && result_stall;
    assign result_held = result_valid && result_stall;
    assign result_word = {cx_reg, cy_reg};

    `CFB_ASSERT_ALWAYS(a_rw_exclusive, !(load_we && comp_re), "store written and read together")
    `CFB_ASSERT_RUN(a_stall_full, item_stall |-> pipe_full, "input stalled with a bubble")
    `CFB_ASSERT_RUN(a_compose_enters, comp_re |=> v1_reg, "compose transfer lost at read stage")
    `CFB_ASSERT_RUN(a_result_holds, result_held |=> result_valid, "stalled result dropped")
    `CFB_ASSERT_RUN(a_data_holds, result_held |=> $stable(result_word), "stalled result changed")

endmodule
